/* hdl/htd_pkg.sv */
// ----------------------------------------------------------------------------
// htd_pkg
// Shared types and codes of the tree walk byte decoder: item kinds, queued
// command format, result format and error codes.
// ----------------------------------------------------------------------------
package htd_pkg;

  // literal codes are below this value, node references are node plus this
  localparam int unsigned LitLimit = 256;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_BYTE  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    OP_WRITE      = 3'd0,
    OP_REJECT     = 3'd1,
    OP_START      = 3'd2,
    OP_START_ZERO = 3'd3,
    OP_BYTE       = 3'd4
  } op_e;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BAD_NODE  = 2'd1;
  localparam logic [1:0] ERR_EXHAUSTED = 2'd2;
  localparam logic [1:0] ERR_REJECT    = 2'd3;

  // node entry: bits 8..0 zero child, bits 17..9 one child
  localparam int unsigned EntryBits = 18;

  typedef struct packed {
    op_e                  op;
    logic [7:0]           idx;
    logic [EntryBits-1:0] entry;
    logic [23:0]          len;
    logic [7:0]           data;
    logic                 last;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        has_byte;
    logic        done_res;
    logic        error;
    logic [1:0]  error_code;
    logic [23:0] bytes_used;
  } res_t;

endpackage

/* hdl/htd_ram.sv */
// ----------------------------------------------------------------------------
// htd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module htd_ram #(
  parameter int unsigned WIDTH = 18,
  parameter int unsigned DEPTH = 255
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/htd_fifo.sv */
// ----------------------------------------------------------------------------
// htd_fifo
// Small register based queue with push/pop handshake and full/empty flags.
// ----------------------------------------------------------------------------
module htd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d;
  logic [AW-1:0]    rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

/* hdl/htd_front.sv */
// ----------------------------------------------------------------------------
// htd_front
// Classifies incoming items into queued commands and validates node loads.
// ----------------------------------------------------------------------------
module htd_front #(
  parameter int unsigned NODE_COUNT  = 255,
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic          push_i,
  input  logic          full_i,
  input  logic [1:0]    kind_i,
  input  logic [7:0]    node_index_i,
  input  logic [15:0]   zero_child_i,
  input  logic [15:0]   one_child_i,
  input  logic [23:0]   expected_length_i,
  input  logic [7:0]    data_byte_i,
  input  logic          last_byte_i,
  output logic          cmd_valid_o,
  output htd_pkg::cmd_t cmd_o
);
  import htd_pkg::*;

  localparam logic [15:0] CodeLimit = 16'(LitLimit + NODE_COUNT);

  logic bad_load;
  logic zero_len;

  assign bad_load = (node_index_i >= 8'(NODE_COUNT)) ||
                    (zero_child_i >= CodeLimit) || (one_child_i >= CodeLimit);
  assign zero_len = (LENGTH_BITS'(expected_length_i) == '0);

  always_comb begin
    cmd_valid_o = push_i && !full_i;
    cmd_o.op    = OP_BYTE;
    cmd_o.idx   = node_index_i;
    cmd_o.entry = {one_child_i[8:0], zero_child_i[8:0]};
    cmd_o.len   = expected_length_i;
    cmd_o.data  = data_byte_i;
    cmd_o.last  = last_byte_i;
    case (kind_i)
      KIND_LOAD:  cmd_o.op = bad_load ? OP_REJECT : OP_WRITE;
      KIND_START: cmd_o.op = zero_len ? OP_START_ZERO : OP_START;
      KIND_BYTE:  cmd_o.op = OP_BYTE;
      // unknown kind is taken and dropped
      default:    cmd_valid_o = 1'b0;
    endcase
  end

endmodule

/* hdl/htd_back.sv */
// ----------------------------------------------------------------------------
// htd_back
// Executes queued commands: node writes, chunk control and the bitwise tree
// walk over the node RAM.
// ----------------------------------------------------------------------------
module htd_back #(
  parameter int unsigned NODE_COUNT  = 255,
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  htd_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output htd_pkg::res_t res_o
);
  import htd_pkg::*;

  localparam int unsigned NW = $clog2(NODE_COUNT);
  localparam logic [NW-1:0] RootNode = NW'(NODE_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WALK = 2'b10
  } state_e;

  state_e                 state_q, state_d;
  logic [NW-1:0]          node_q, node_d;
  logic [LENGTH_BITS-1:0] remain_q, remain_d;
  logic [LENGTH_BITS-1:0] used_q, used_d;
  logic                   active_q, active_d;
  logic [2:0]             bit_q, bit_d;
  logic [7:0]             data_q, data_d;
  logic                   last_q, last_d;

  logic                   ram_we, ram_re;
  logic [NW-1:0]          ram_raddr;
  logic [EntryBits-1:0]   ram_rdata;
  logic [8:0]             code;
  logic [LENGTH_BITS-1:0] remain_dec;
  logic [23:0]            used_out;

  htd_ram #(
    .WIDTH (EntryBits),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (NW'(cmd_i.idx)),
    .wdata_i (cmd_i.entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign code       = data_q[bit_q] ? ram_rdata[17:9] : ram_rdata[8:0];
  assign remain_dec = remain_q - LENGTH_BITS'(1);
  assign used_out   = 24'(used_q);

  always_comb begin
    state_d    = state_q;
    node_d     = node_q;
    remain_d   = remain_q;
    used_d     = used_q;
    active_d   = active_q;
    bit_d      = bit_q;
    data_d     = data_q;
    last_d     = last_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = node_q;
    case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            OP_WRITE: ram_we = 1'b1;
            OP_REJECT: begin
              res_push_o       = 1'b1;
              res_o.error      = 1'b1;
              res_o.error_code = ERR_REJECT;
            end
            OP_START: begin
              node_d   = RootNode;
              used_d   = '0;
              remain_d = LENGTH_BITS'(cmd_i.len);
              active_d = 1'b1;
            end
            OP_START_ZERO: begin
              node_d         = RootNode;
              used_d         = '0;
              remain_d       = '0;
              active_d       = 1'b0;
              res_push_o     = 1'b1;
              res_o.done_res = 1'b1;
            end
            OP_BYTE: begin
              if (active_q) begin
                if (used_q != '1) begin
                  used_d = used_q + LENGTH_BITS'(1);
                end
                data_d    = cmd_i.data;
                last_d    = cmd_i.last;
                bit_d     = '0;
                ram_re    = 1'b1;
                ram_raddr = node_q;
                state_d   = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (!res_full_i) begin
          if (!code[8]) begin
            // literal: emit and return to the root
            node_d         = RootNode;
            remain_d       = remain_dec;
            res_push_o     = 1'b1;
            res_o.out_byte = code[7:0];
            res_o.has_byte = 1'b1;
            if (remain_dec == '0) begin
              res_o.done_res   = 1'b1;
              res_o.bytes_used = used_out;
              active_d         = 1'b0;
              state_d          = S_IDLE;
            end else if (bit_q == 3'd7) begin
              if (last_q) begin
                res_o.done_res   = 1'b1;
                res_o.error      = 1'b1;
                res_o.error_code = ERR_EXHAUSTED;
                res_o.bytes_used = used_out;
                active_d         = 1'b0;
              end
              state_d = S_IDLE;
            end else begin
              bit_d     = bit_q + 3'd1;
              ram_re    = 1'b1;
              ram_raddr = RootNode;
            end
          end else if (code[7:0] >= 8'(NODE_COUNT)) begin
            res_push_o       = 1'b1;
            res_o.done_res   = 1'b1;
            res_o.error      = 1'b1;
            res_o.error_code = ERR_BAD_NODE;
            res_o.bytes_used = used_out;
            node_d           = RootNode;
            active_d         = 1'b0;
            state_d          = S_IDLE;
          end else if (bit_q == 3'd7) begin
            // byte used up in the middle of a code
            node_d = NW'(code[7:0]);
            if (last_q) begin
              res_push_o       = 1'b1;
              res_o.done_res   = 1'b1;
              res_o.error      = 1'b1;
              res_o.error_code = ERR_EXHAUSTED;
              res_o.bytes_used = used_out;
              node_d           = RootNode;
              active_d         = 1'b0;
            end
            state_d = S_IDLE;
          end else begin
            node_d    = NW'(code[7:0]);
            bit_d     = bit_q + 3'd1;
            ram_re    = 1'b1;
            ram_raddr = NW'(code[7:0]);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      node_q   <= RootNode;
      remain_q <= '0;
      used_q   <= '0;
      active_q <= 1'b0;
      bit_q    <= '0;
    end else begin
      state_q  <= state_d;
      node_q   <= node_d;
      remain_q <= remain_d;
      used_q   <= used_d;
      active_q <= active_d;
      bit_q    <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  ast_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_push_o && res_full_i))
    else $error("result pushed into a full queue");

  ast_walk_needs_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> active_q)
    else $error("tree walk without an open chunk");

  ast_node_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_q <= RootNode)
    else $error("current node beyond the tree");

  ast_stall_holds_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && res_full_i) |=> $stable(ram_rdata) && $stable(bit_q))
    else $error("node read lost during a stall");

endmodule

/* hdl/huffman_tree_byte_decoder_unit.sv */
// ----------------------------------------------------------------------------
// huffman_tree_byte_decoder_unit
// Huffman decoder on a stored binary code tree, one bit per unstalled cycle.
// ----------------------------------------------------------------------------
// Items enter through a queue style port (push/full) and results leave
// through another (pop/empty). A load item writes one node of the tree, a
// start item opens a chunk of a given decoded length, and compressed bytes
// are then decoded least significant bit first. A compressed byte is walked
// in the execution stage: the current node is first fetched from the node
// RAM, then each bit is looked up in turn, since each bit's lookup needs the
// registered read data of the previous one. The input side keeps taking
// items into a two entry command queue while a byte is being walked, and
// results collect in a four entry result queue; the walk pauses whenever
// that queue is full. The node RAM holds no defined value until a node is
// written; decoding through a node that was never loaded gives undefined
// results.
module huffman_tree_byte_decoder_unit #(
  parameter int unsigned NODE_COUNT  = 255,
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  node_index_i,
  input  logic [15:0] zero_child_i,
  input  logic [15:0] one_child_i,
  input  logic [23:0] expected_length_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // result side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        has_byte_o,
  output logic        done_res_o,
  output logic        error_o,
  output logic [1:0]  error_code_o,
  output logic [23:0] bytes_used_o
);
  import htd_pkg::*;

  localparam int unsigned CmdDepth = 2;
  localparam int unsigned ResDepth = 4;

  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  res_t res_in, res_out;
  logic res_push, res_full;

  assign full = cmd_full;

  // classify and validate; kind 3 is taken but never queued
  htd_front #(
    .NODE_COUNT  (NODE_COUNT),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .push_i            (push),
    .full_i            (cmd_full),
    .kind_i            (kind_i),
    .node_index_i      (node_index_i),
    .zero_child_i      (zero_child_i),
    .one_child_i       (one_child_i),
    .expected_length_i (expected_length_i),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .cmd_valid_o       (cmd_push),
    .cmd_o             (cmd_in)
  );

  // decouples item acceptance from the tree walk
  htd_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  // node writes, chunk bookkeeping and bitwise walk
  htd_back #(
    .NODE_COUNT  (NODE_COUNT),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // results wait here until the consumer takes each transaction
  htd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign out_byte_o   = res_out.out_byte;
  assign has_byte_o   = res_out.has_byte;
  assign done_res_o   = res_out.done_res;
  assign error_o      = res_out.error;
  assign error_code_o = res_out.error_code;
  assign bytes_used_o = res_out.bytes_used;

endmodule

/* tb/huffman_tree_byte_decoder_unit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_tree_byte_decoder_unit_test
// Self-checking bench for the tree walk byte decoder.
// ----------------------------------------------------------------------------
// Every node of the code tree is loaded first, so a walk never reads an
// unwritten entry. Random trees only point from a node to a lower-numbered
// node, which keeps every walk finite. A short directed part covers the
// special cases, then random chunks of compressed bytes are streamed through
// with random node reloads, rejected loads and ignored items mixed in. A
// scoreboard predicts the results of each accepted transaction and checks
// each popped result field by field.
// ----------------------------------------------------------------------------
module huffman_tree_byte_decoder_unit_test;
  import htd_pkg::*;

  localparam int unsigned NodeCount   = 255;
  localparam logic [7:0]  RootNode    = 8'd254;
  // first child code that a load must reject
  localparam int unsigned CodeLimit   = LitLimit + NodeCount;
  // kind code outside the defined set, dropped by the block
  localparam logic [1:0]  KIND_IGNORED = 2'd3;
  localparam int unsigned RandomItems = 80;
  // from here on neither side idles
  localparam int unsigned CalmAfter   = 65;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  node_index;
    logic [15:0] zero_child;
    logic [15:0] one_child;
    logic [23:0] expected_length;
    logic [7:0]  data_byte;
    logic        last_byte;
  } code_item_t;

  // tracks the tree, the walk and the results still owed by the block
  class decode_scoreboard;
    bit [17:0]   node_table [NodeCount];
    logic [7:0]  walk_node;
    logic [23:0] left_to_emit;
    logic [23:0] bytes_taken;
    bit          in_chunk;
    res_t        due_results [$];
    int unsigned mismatches;

    function new();
      walk_node    = RootNode;
      left_to_emit = '0;
      bytes_taken  = '0;
      in_chunk     = 1'b0;
      mismatches   = 0;
    endfunction

    function void add_due(logic [7:0] b, logic has, logic done, logic err,
                          logic [1:0] code, logic [23:0] used);
      res_t r;
      r.out_byte   = b;
      r.has_byte   = has;
      r.done_res   = done;
      r.error      = err;
      r.error_code = code;
      r.bytes_used = used;
      due_results.push_back(r);
    endfunction

    // one compressed byte, bit 0 first
    function void walk_byte(logic [7:0] data, logic last);
      logic [17:0] entry;
      logic [8:0]  code;
      if (bytes_taken != '1) bytes_taken++;
      for (int b = 0; b < 8; b++) begin
        entry = node_table[walk_node];
        code  = data[b] ? entry[17:9] : entry[8:0];
        if (code < LitLimit) begin
          walk_node = RootNode;
          left_to_emit--;
          if (left_to_emit == 0) begin
            add_due(code[7:0], 1'b1, 1'b1, 1'b0, ERR_NONE, bytes_taken);
            in_chunk = 1'b0;
            return;
          end
          if (b == 7 && last) begin
            add_due(code[7:0], 1'b1, 1'b1, 1'b1, ERR_EXHAUSTED, bytes_taken);
            in_chunk = 1'b0;
            return;
          end
          add_due(code[7:0], 1'b1, 1'b0, 1'b0, ERR_NONE, '0);
        end else if (code >= CodeLimit) begin
          add_due('0, 1'b0, 1'b1, 1'b1, ERR_BAD_NODE, bytes_taken);
          walk_node = RootNode;
          in_chunk  = 1'b0;
          return;
        end else begin
          walk_node = 8'(code - LitLimit);
        end
      end
      if (last) begin
        add_due('0, 1'b0, 1'b1, 1'b1, ERR_EXHAUSTED, bytes_taken);
        walk_node = RootNode;
        in_chunk  = 1'b0;
      end
    endfunction

    function void note_item(code_item_t it);
      case (it.kind)
        KIND_LOAD: begin
          if (it.node_index >= NodeCount || it.zero_child >= CodeLimit ||
              it.one_child >= CodeLimit)
            add_due('0, 1'b0, 1'b0, 1'b1, ERR_REJECT, '0);
          else
            node_table[it.node_index] = {it.one_child[8:0], it.zero_child[8:0]};
        end
        KIND_START: begin
          walk_node    = RootNode;
          bytes_taken  = '0;
          left_to_emit = it.expected_length;
          in_chunk     = (it.expected_length != 0);
          if (it.expected_length == 0)
            add_due('0, 1'b0, 1'b1, 1'b0, ERR_NONE, '0);
        end
        KIND_BYTE: begin
          if (in_chunk) walk_byte(it.data_byte, it.last_byte);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string field, logic [23:0] want, logic [23:0] seen);
      if (want !== seen) begin
        mismatches++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, seen);
      end
    endfunction

    function void check_result(res_t seen);
      res_t want;
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual byte 0x%0h has %0b done %0b code %0d",
                 $time, seen.out_byte, seen.has_byte, seen.done_res, seen.error_code);
        return;
      end
      want = due_results.pop_front();
      compare_field("out_byte", 24'(want.out_byte), 24'(seen.out_byte));
      compare_field("has_byte", 24'(want.has_byte), 24'(seen.has_byte));
      compare_field("done_res", 24'(want.done_res), 24'(seen.done_res));
      compare_field("error", 24'(want.error), 24'(seen.error));
      compare_field("error_code", 24'(want.error_code), 24'(seen.error_code));
      compare_field("bytes_used", want.bytes_used, seen.bytes_used);
    endfunction
  endclass

  // every input known from time zero
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic [1:0]  kind_i = '0;
  logic [7:0]  node_index_i = '0;
  logic [15:0] zero_child_i = '0;
  logic [15:0] one_child_i = '0;
  logic [23:0] expected_length_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  out_byte_o;
  logic        has_byte_o;
  logic        done_res_o;
  logic        error_o;
  logic [1:0]  error_code_o;
  logic [23:0] bytes_used_o;

  decode_scoreboard sb;
  int unsigned item_count = 0;   // transactions that do something in the block
  bit          sender_gappy = 1'b0;
  bit          calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned run_left = 0;

  huffman_tree_byte_decoder_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .kind_i            (kind_i),
    .node_index_i      (node_index_i),
    .zero_child_i      (zero_child_i),
    .one_child_i       (one_child_i),
    .expected_length_i (expected_length_i),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .empty             (empty),
    .pop               (pop),
    .out_byte_o        (out_byte_o),
    .has_byte_o        (has_byte_o),
    .done_res_o        (done_res_o),
    .error_o           (error_o),
    .error_code_o      (error_code_o),
    .bytes_used_o      (bytes_used_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // fields the item kind does not use carry random values
  function automatic code_item_t junk_item();
    code_item_t it;
    it.kind            = 2'($urandom);
    it.node_index      = 8'($urandom);
    it.zero_child      = 16'($urandom);
    it.one_child       = 16'($urandom);
    it.expected_length = 24'($urandom);
    it.data_byte       = 8'($urandom);
    it.last_byte       = 1'($urandom);
    return it;
  endfunction

  // literal, or a reference to a lower node so that walks always finish
  function automatic int unsigned pick_child(int unsigned idx);
    if (idx == 0 || $urandom_range(0, 4) < 3) return $urandom_range(0, 255);
    return LitLimit + $urandom_range(0, idx - 1);
  endfunction

  // called just after the clock rises; returns just after the item is accepted
  task automatic send_item(code_item_t it);
    if (!calm && sender_gappy && $urandom_range(0, 2) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    push              <= 1'b1;
    kind_i            <= it.kind;
    node_index_i      <= it.node_index;
    zero_child_i      <= it.zero_child;
    one_child_i       <= it.one_child;
    expected_length_i <= it.expected_length;
    data_byte_i       <= it.data_byte;
    last_byte_i       <= it.last_byte;
    do @(posedge clk_i); while (full);
    // kind 3 and bytes outside a chunk do nothing in the block
    if (!(it.kind == KIND_IGNORED || (it.kind == KIND_BYTE && !sb.in_chunk)))
      item_count++;
    sb.note_item(it);
  endtask

  task automatic send_load(int unsigned idx, int unsigned zero, int unsigned one);
    code_item_t it;
    it            = junk_item();
    it.kind       = KIND_LOAD;
    it.node_index = 8'(idx);
    it.zero_child = 16'(zero);
    it.one_child  = 16'(one);
    send_item(it);
  endtask

  task automatic send_start(logic [23:0] len);
    code_item_t it;
    it                 = junk_item();
    it.kind            = KIND_START;
    it.expected_length = len;
    send_item(it);
  endtask

  task automatic send_byte(logic [7:0] data, logic last);
    code_item_t it;
    it           = junk_item();
    it.kind      = KIND_BYTE;
    it.data_byte = data;
    it.last_byte = last;
    send_item(it);
  endtask

  // sender holds off until every owed result has been popped
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (sb.due_results.size() != 0);
  endtask

  // one chunk: start, then bytes until the chunk closes
  task automatic run_chunk();
    int unsigned sel;
    int unsigned cap;
    int unsigned n;
    int unsigned idx;
    logic [23:0] len;
    sel = $urandom_range(0, 19);
    if (sel == 0) len = '0;
    else if (sel == 1) len = 24'($urandom);
    else len = 24'($urandom_range(1, 12));
    send_start(len);
    cap = $urandom_range(2, 16);
    n = 0;
    while (sb.in_chunk) begin
      if ($urandom_range(0, 29) == 0) begin
        // tree reload in the middle of a chunk
        idx = $urandom_range(0, NodeCount - 1);
        send_load(idx, pick_child(idx), pick_child(idx));
      end else if ($urandom_range(0, 39) == 0) begin
        // new start drops the open chunk without a result
        send_start(24'($urandom_range(1, 12)));
      end
      send_byte(8'($urandom), (n + 1 >= cap) || ($urandom_range(0, 11) == 0));
      n++;
    end
  endtask

  // result side: stall bursts and stall free runs, none near the end
  always @(posedge clk_i) begin
    if (calm) begin
      pop <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (run_left != 0) begin
      run_left--;
      pop <= 1'b1;
    end else if ($urandom_range(0, 1) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      pop <= 1'b0;
    end else begin
      run_left = $urandom_range(1, 40) - 1;
      pop <= 1'b1;
    end
  end

  // a result transaction completes at an edge with pop high and empty low
  always @(posedge clk_i) begin : watch_results
    res_t seen;
    if (rst_ni && pop && !empty) begin
      seen.out_byte   = out_byte_o;
      seen.has_byte   = has_byte_o;
      seen.done_res   = done_res_o;
      seen.error      = error_o;
      seen.error_code = error_code_o;
      seen.bytes_used = bytes_used_o;
      sb.check_result(seen);
    end
  end

  initial begin
    int unsigned base;
    int unsigned pick;
    int unsigned idx;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // whole tree written up front, no walk can reach an unwritten node
    for (int unsigned i = 0; i < NodeCount; i++)
      send_load(i, pick_child(i), pick_child(i));

    // root with two literals: one result per bit
    send_load(NodeCount - 1, 'h41, 'hC3);
    send_start(24'd3);
    send_byte(8'h05, 1'b0);          // chunk done at bit 2, rest of byte dropped
    send_start(24'd20);
    send_byte(8'hFF, 1'b0);          // eight results from one byte
    send_byte(8'h00, 1'b1);          // exhausted on a result that carries a byte
    // root zero child goes down to node 0, one child is a literal
    send_load(0, 0, 255);
    send_load(NodeCount - 1, LitLimit, 255);
    send_start(24'd5);
    send_byte(8'h40, 1'b1);          // exhausted mid walk: extra result without byte
    send_start(24'd0);               // zero length chunk
    send_load(255, 0, 0);            // index out of range
    send_load(3, CodeLimit, 0);      // zero child out of range
    send_load(3, 0, 'hFFFF);         // one child out of range
    send_load(NodeCount - 1, 0, CodeLimit - 1);  // highest legal code, root loops on 1
    send_start(24'd2);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h00, 1'b0);
    begin
      code_item_t odd;
      odd      = junk_item();
      odd.kind = KIND_IGNORED;
      send_item(odd);
    end
    send_byte(8'hA5, 1'b1);          // no chunk open, ignored
    send_load(NodeCount - 1, 'h10, 'h20);
    send_start(24'd9);
    send_byte(8'h0F, 1'b0);
    send_start(24'd1);               // abandons the chunk with one byte still owed
    send_byte(8'h01, 1'b0);
    send_start(24'hFFFFFF);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    send_load(NodeCount - 1, pick_child(NodeCount - 1), pick_child(NodeCount - 1));
    wait_drained();

    // random part, mostly well formed chunks
    base = item_count;
    while (item_count - base < RandomItems) begin
      calm = (item_count - base >= CalmAfter);
      sender_gappy = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        run_chunk();
      end else if (pick < 82) begin
        idx = $urandom_range(0, NodeCount - 1);
        send_load(idx, pick_child(idx), pick_child(idx));
      end else if (pick < 92) begin
        idx = $urandom_range(0, NodeCount - 1);
        case ($urandom_range(0, 2))
          0: send_load(255, pick_child(idx), pick_child(idx));
          1: send_load(idx, $urandom_range(CodeLimit, 'hFFFF), pick_child(idx));
          default: send_load(idx, pick_child(idx), $urandom_range(CodeLimit, 'hFFFF));
        endcase
      end else if (pick < 97) begin
        if ($urandom_range(0, 1) == 0) begin
          code_item_t odd;
          odd      = junk_item();
          odd.kind = KIND_IGNORED;
          send_item(odd);
        end else begin
          send_byte(8'($urandom), 1'($urandom));
        end
      end else begin
        wait_drained();
      end
    end

    calm = 1'b1;
    wait_drained();
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("huffman_tree_byte_decoder_unit test passed");
    else
      $display("huffman_tree_byte_decoder_unit test failed");
    $finish;
  end

  // well above the slowest correct run with every stall at its longest
  initial begin
    #10_000_000;
    $display("huffman_tree_byte_decoder_unit test failed");
    $finish;
  end

endmodule
